@@ sv/sensor_fault_edge_detector_assert.svh @@
// Assertion macros for the sensor fault edge detector checker.
// No dependencies; included by the checker file only.
`ifndef SENSOR_FAULT_EDGE_DETECTOR_ASSERT_SVH
`define SENSOR_FAULT_EDGE_DETECTOR_ASSERT_SVH

// Checked property, switched off while reset is held.
`define SFED_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also runs across reset.
`define SFED_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/sfed_pkg.sv @@
// Shared types and constants for the sensor fault edge detector.
// No dependencies; used by the front, queue, back and top-level modules.
package sfed_pkg;

    localparam int SENSOR_W = 6;
    localparam int SAMPLE_W = 32;
    localparam int TIME_W   = 48;
    localparam int LIMIT_W  = 32;
    localparam int STATUS_W = 6;

    // status bit positions
    localparam int SB_HAS_LAST    = 0;
    localparam int SB_TIMER       = 1;
    localparam int SB_FAULT       = 2;
    localparam int SB_DISC_FIRED  = 3;
    localparam int SB_STUCK_FIRED = 4;
    localparam int SB_OOR_FIRED   = 5;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        ACT_CONN  = 2'd0,
        ACT_STUCK = 2'd1,
        ACT_RANGE = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } t_back_state;

    // classified check, as queued between front and back
    typedef struct packed {
        t_action              action;
        logic [SENSOR_W-1:0]  sensor;
        logic                 in_table;
        logic                 connected;
        logic [SAMPLE_W-1:0]  sample;
        logic [TIME_W-1:0]    now_ms;
        logic [LIMIT_W-1:0]   stuck_limit_ms;
        logic                 oor;
    } t_item;

    // one health table entry
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TIME_W-1:0]    stuck_start_ms;
        logic [SAMPLE_W-1:0]  last_sample;
    } t_entry;

endpackage

@@ sv/sfed_front.sv @@
// Front end: takes input beats, decodes the check and does the range compare.
// Depends on sfed_pkg.
module sfed_front #(
    parameter int SENSOR_COUNT = 64
) (
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_action,
    input  logic [sfed_pkg::SENSOR_W-1:0]   i_sensor,
    input  logic                            i_connected,
    input  logic signed [sfed_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [sfed_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [sfed_pkg::LIMIT_W-1:0]    i_stuck_limit_ms,
    input  logic signed [sfed_pkg::SAMPLE_W-1:0] i_range_low,
    input  logic signed [sfed_pkg::SAMPLE_W-1:0] i_range_high,
    input  logic                            i_clearing,
    input  logic                            i_push_ready,
    output logic                            o_push_valid,
    output sfed_pkg::t_item                 o_push_item
);

    // no beats taken while the table is being cleared
    assign o_ready      = i_push_ready && !i_clearing;
    assign o_push_valid = i_valid && o_ready;

    always_comb begin
        o_push_item.action         = sfed_pkg::t_action'(i_action);
        o_push_item.sensor         = i_sensor;
        o_push_item.in_table       = (32'(i_sensor) < 32'(SENSOR_COUNT));
        o_push_item.connected      = i_connected;
        o_push_item.sample         = i_sample;
        o_push_item.now_ms         = i_now_ms;
        o_push_item.stuck_limit_ms = i_stuck_limit_ms;
        // inverted bounds leave every sample out of range
        o_push_item.oor            = (i_sample < i_range_low) || (i_sample > i_range_high);
    end

endmodule

@@ sv/sfed_queue.sv @@
// Short FIFO of classified checks between front and back.
// Depends on sfed_pkg.
module sfed_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  sfed_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output sfed_pkg::t_item o_pop_item
);

    sfed_pkg::t_item                r_slot [sfed_pkg::QUEUE_DEPTH];
    logic [sfed_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [sfed_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [sfed_pkg::QCNT_W-1:0]    r_count;
    logic                           push;
    logic                           pop;

    assign o_push_ready = (r_count != sfed_pkg::QCNT_W'(sfed_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    function automatic logic [sfed_pkg::QPTR_W-1:0] ptr_inc(
        input logic [sfed_pkg::QPTR_W-1:0] ptr
    );
        return (ptr == sfed_pkg::QPTR_W'(sfed_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ sv/sfed_back.sv @@
// Back end: health table memory, clear sweep, read-modify-write, result register.
// Depends on sfed_pkg.
module sfed_back #(
    parameter int SENSOR_COUNT = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  sfed_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_alarm,
    output logic            o_healthy
);

    localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    sfed_pkg::t_back_state  r_state;
    sfed_pkg::t_back_state  n_state;
    logic [AW-1:0]          r_clr_cnt;
    sfed_pkg::t_item        r_item;
    sfed_pkg::t_entry       r_rd;
    sfed_pkg::t_entry       r_mem [SENSOR_COUNT];
    logic                   r_out_valid;
    logic                   r_out_alarm;
    logic                   r_out_healthy;

    logic                   slot_free;
    logic                   clr_last;
    logic                   exec_fire;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          rd_addr;
    sfed_pkg::t_entry       mem_wdata;
    sfed_pkg::t_entry       upd_entry;
    logic                   upd_alarm;
    logic                   upd_healthy;
    logic [sfed_pkg::TIME_W-1:0] elapsed;
    logic                   due;

    assign slot_free = !r_out_valid || i_ready;
    assign clr_last  = (r_clr_cnt == AW'(SENSOR_COUNT - 1));
    assign rd_addr   = AW'(i_q_item.sensor);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sfed_pkg::BK_CLEAR: if (clr_last)  n_state = sfed_pkg::BK_IDLE;
            sfed_pkg::BK_IDLE:  if (i_q_valid) n_state = sfed_pkg::BK_EXEC;
            sfed_pkg::BK_EXEC:  if (slot_free) n_state = sfed_pkg::BK_IDLE;
            default:            n_state = sfed_pkg::BK_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop    = 1'b0;
        o_clearing = 1'b0;
        exec_fire  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_cnt;
        mem_wdata  = '0;
        unique case (r_state)
            sfed_pkg::BK_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
            end
            sfed_pkg::BK_IDLE: begin
                o_q_pop = i_q_valid;
            end
            sfed_pkg::BK_EXEC: begin
                exec_fire = slot_free;
                mem_we    = slot_free && r_item.in_table;
                mem_waddr = AW'(r_item.sensor);
                mem_wdata = upd_entry;
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    // repeat timer: a time before the start counts as not yet elapsed
    assign elapsed = r_item.now_ms - r_rd.stuck_start_ms;
    assign due     = (r_item.now_ms >= r_rd.stuck_start_ms)
                  && (elapsed >= {{(sfed_pkg::TIME_W - sfed_pkg::LIMIT_W){1'b0}},
                                  r_item.stuck_limit_ms});

    // entry update
    always_comb begin
        upd_entry = r_rd;
        upd_alarm = 1'b0;
        unique case (r_item.action)
            sfed_pkg::ACT_CONN: begin
                if (!r_item.connected) begin
                    if (!r_rd.status[sfed_pkg::SB_DISC_FIRED]) begin
                        upd_entry.status[sfed_pkg::SB_DISC_FIRED] = 1'b1;
                        upd_alarm = 1'b1;
                    end
                end else begin
                    upd_entry.status[sfed_pkg::SB_DISC_FIRED] = 1'b0;
                end
            end
            sfed_pkg::ACT_STUCK: begin
                if (!(r_rd.status[sfed_pkg::SB_HAS_LAST]
                      && (r_rd.last_sample == r_item.sample))) begin
                    upd_entry.status[sfed_pkg::SB_TIMER]       = 1'b0;
                    upd_entry.status[sfed_pkg::SB_STUCK_FIRED] = 1'b0;
                    upd_entry.status[sfed_pkg::SB_HAS_LAST]    = 1'b1;
                    upd_entry.last_sample = r_item.sample;
                end else if (!r_rd.status[sfed_pkg::SB_TIMER]) begin
                    // first repeat only starts the timer
                    upd_entry.status[sfed_pkg::SB_TIMER] = 1'b1;
                    upd_entry.stuck_start_ms = r_item.now_ms;
                end else if (due && !r_rd.status[sfed_pkg::SB_STUCK_FIRED]) begin
                    upd_entry.status[sfed_pkg::SB_STUCK_FIRED] = 1'b1;
                    upd_entry.status[sfed_pkg::SB_FAULT]       = 1'b1;
                    upd_alarm = 1'b1;
                end
            end
            sfed_pkg::ACT_RANGE: begin
                if (r_item.oor) begin
                    if (!r_rd.status[sfed_pkg::SB_OOR_FIRED]) begin
                        upd_entry.status[sfed_pkg::SB_OOR_FIRED] = 1'b1;
                        upd_entry.status[sfed_pkg::SB_FAULT]     = 1'b1;
                        upd_alarm = 1'b1;
                    end
                end else begin
                    upd_entry.status[sfed_pkg::SB_OOR_FIRED] = 1'b0;
                end
            end
            sfed_pkg::ACT_NONE: begin
                upd_entry = r_rd;
            end
        endcase
        upd_healthy = !upd_entry.status[sfed_pkg::SB_FAULT];
        // sensor beyond the table: no change, reported healthy
        if (!r_item.in_table) begin
            upd_alarm   = 1'b0;
            upd_healthy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfed_pkg::BK_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sfed_pkg::BK_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (exec_fire) begin
            r_out_alarm   <= upd_alarm;
            r_out_healthy <= upd_healthy;
        end
    end

    // health table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (o_q_pop) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_alarm   = r_out_alarm;
    assign o_healthy = r_out_healthy;

endmodule

@@ sv/sensor_fault_edge_detector.sv @@
// Sensor fault edge detector: a per-sensor health table with one-shot alarms.
// Input beat (i_valid/o_ready): i_action, i_sensor, i_connected, i_sample (Q16.16),
//   i_now_ms, i_stuck_limit_ms, i_range_low, i_range_high.
// Result beat (o_valid/i_ready): o_alarm (check fired its edge now), o_healthy
//   (sensor's sticky fault flag clear). Exactly one result per input beat, in order.
// Flow: an accepted beat is stored in the queue, then popped in IDLE while its
//   table entry is read; in EXEC the entry is updated, written back and the result
//   registered. The back end takes one check at a time, the next only after EXEC;
//   a 2-entry queue lets the front take beats back to back until it fills.
// Reset (synchronous, i_rst_n low): control state clears, then a sweep writes
//   every table entry to zero, one a cycle; o_ready stays low during it.
// Receiver stall: the result register holds its beat while i_ready is low; the
//   back end waits on it and the queue keeps taking beats until full, then
//   o_ready drops.
// Depends on sfed_pkg, sfed_front, sfed_queue, sfed_back.
module sensor_fault_edge_detector #(
    parameter int SENSOR_COUNT = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_action,
    input  logic [sfed_pkg::SENSOR_W-1:0]        i_sensor,
    input  logic                                 i_connected,
    input  logic signed [sfed_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [sfed_pkg::TIME_W-1:0]          i_now_ms,
    input  logic [sfed_pkg::LIMIT_W-1:0]         i_stuck_limit_ms,
    input  logic signed [sfed_pkg::SAMPLE_W-1:0] i_range_low,
    input  logic signed [sfed_pkg::SAMPLE_W-1:0] i_range_high,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_alarm,
    output logic                                 o_healthy
);

    logic            push_valid;
    logic            push_ready;
    sfed_pkg::t_item push_item;
    logic            pop_valid;
    logic            pop;
    sfed_pkg::t_item pop_item;
    logic            clearing;

    // front: decode and range compare, no state
    sfed_front #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_action         (i_action),
        .i_sensor         (i_sensor),
        .i_connected      (i_connected),
        .i_sample         (i_sample),
        .i_now_ms         (i_now_ms),
        .i_stuck_limit_ms (i_stuck_limit_ms),
        .i_range_low      (i_range_low),
        .i_range_high     (i_range_high),
        .i_clearing       (clearing),
        .i_push_ready     (push_ready),
        .o_push_valid     (push_valid),
        .o_push_item      (push_item)
    );

    // decoupling queue
    sfed_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_item   (pop_item)
    );

    // back: table read-modify-write and result register
    sfed_back #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (pop_valid),
        .i_q_item   (pop_item),
        .o_q_pop    (pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_alarm    (o_alarm),
        .o_healthy  (o_healthy)
    );

endmodule

@@ sv/sfed_checker.sv @@
// Port-level checks for the sensor fault edge detector, bound to the top level.
// Depends on sensor_fault_edge_detector_assert.svh.
`include "sensor_fault_edge_detector_assert.svh"

module sfed_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_alarm,
    input logic o_healthy
);

    // no result beat straight out of reset
    `SFED_ASSERT_ALWAYS(a_no_result_after_rst, i_clk,
        !i_rst_n |=> !o_valid, "result after reset")

    // clear sweep blocks input in the cycle after reset
    `SFED_ASSERT_ALWAYS(a_clear_blocks_input, i_clk,
        !i_rst_n |=> !o_ready, "input taken during clear")

    // nothing in flight can reach the output: reset clears the queue and result register
    `SFED_ASSERT_ALWAYS(a_no_early_result, i_clk,
        !i_rst_n |=> ##1 !o_valid, "result too early after reset")

    // a stalled result beat holds
    `SFED_ASSERT(a_result_holds, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_alarm) && $stable(o_healthy),
        "stalled result changed")

endmodule

bind sensor_fault_edge_detector sfed_checker u_sfed_checker (.*);
